/* src/miqr_pkg.sv */
`timescale 1ns / 1ps
// miqr_pkg: shared types and constants of the mono icon quarter rotator.
// No dependencies; used by the interfaces, the top level and the checker.
package miqr_pkg;

  // one display byte holds eight vertical pixels, spread over eight bit banks
  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

endpackage

/* src/miqr_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels of the mono icon quarter rotator.
// Depends on miqr_pkg for the operation and rotation codes.
interface miqr_in_if;
  logic                valid;
  logic                ready;
  miqr_pkg::op_t       operation;
  logic [6:0]          byte_index;
  logic [7:0]          byte_value;
  miqr_pkg::rot_t      rotation;
  logic [1:0]          out_page;
  logic [4:0]          out_column;

  modport source (output valid, operation, byte_index, byte_value, rotation, out_page,
                  out_column, input ready);
  modport sink   (input valid, operation, byte_index, byte_value, rotation, out_page,
                  out_column, output ready);
endinterface

interface miqr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rotated_byte;

  modport source (output valid, rotated_byte, input ready);
  modport sink   (input valid, rotated_byte, output ready);
endinterface

/* src/mono_icon_quarter_rotator_top.sv */
`timescale 1ns / 1ps
// Top level of the mono icon quarter rotator: banked icon store and rotation datapath.
// Depends on miqr_pkg and the channel interfaces in miqr_if.sv.
//
//   channel  | dir | beat content
//   ---------+-----+----------------------------------------------------------
//   in_ch    | in  | operation, byte_index, byte_value, rotation, out_page, out_column
//   out_ch   | out | rotated_byte (one per read beat, none for writes)
//
// One beat per cycle in both directions while out_ch is not stalled. A read accepted
// loads the bank read register, and the output register takes its byte once out_ch
// is free; from there the byte is valid on out_ch.
// The icon sits in eight 1-bit banks skewed by (x + y) mod 8, so any run of eight
// pixels along a row or a column touches each bank once: one read port per bank.
// Reset (rst_n low, synchronous) empties the pipeline; icon contents are kept.
// A stalled output holds its byte and the read stage behind it; the input stalls
// only when both hold a read.
module mono_icon_quarter_rotator_top #(
  parameter int ICON_SIZE = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  miqr_in_if.sink     in_ch,
  miqr_out_if.source  out_ch
);

  localparam int PAGES  = (ICON_SIZE + 7) / 8;
  localparam int DEPTH  = PAGES * ICON_SIZE;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW     = ($clog2(ICON_SIZE) > 5) ? $clog2(ICON_SIZE) : 5;
  localparam int LANES  = miqr_pkg::LANES;
  localparam int LANE_W = miqr_pkg::LANE_W;
  localparam logic [CW-1:0] LAST = CW'(ICON_SIZE - 1);

  // handshake
  logic s1_v_r;
  logic out_v_r;
  logic en1;
  logic en2;
  logic in_acc;
  logic is_rd;
  logic rd_en;
  logic wr_en;

  assign en2         = !out_v_r || out_ch.ready;
  assign en1         = !s1_v_r || en2;
  assign in_ch.ready = en1;
  assign in_acc      = in_ch.valid && en1;
  assign is_rd       = (in_ch.operation == miqr_pkg::OP_READ);
  assign rd_en       = in_acc && is_rd;
  assign wr_en       = in_acc && !is_rd && (int'(in_ch.byte_index) < DEPTH);

  // write side: split byte_index into page and column, rotate the byte into banks
  logic [PW-1:0]     wr_page;
  logic [LANE_W-1:0] wr_col_lo;
  logic [AW-1:0]     wr_addr;
  logic [LANES-1:0]  wr_bits;

  always_comb begin
    wr_page = '0;
    for (int k = 1; k < PAGES; k++) begin
      if (int'(in_ch.byte_index) >= k * ICON_SIZE) begin
        wr_page = PW'(k);
      end
    end
    wr_col_lo = LANE_W'(int'(in_ch.byte_index) - int'(wr_page) * ICON_SIZE);
    wr_addr   = AW'(in_ch.byte_index);
    for (int b = 0; b < LANES; b++) begin
      wr_bits[b] = in_ch.byte_value[LANE_W'(LANE_W'(b) - wr_col_lo)];
    end
  end

  // read side: source pixel, bank and bank address for each output bit
  logic [CW-1:0]     px_y   [LANES];
  logic [CW-1:0]     px_sx  [LANES];
  logic [CW-1:0]     px_sy  [LANES];
  logic [LANE_W-1:0] px_bank[LANES];
  logic [AW-1:0]     px_addr[LANES];
  logic [LANES-1:0]  px_in;
  logic [CW-1:0]     rd_col;
  logic [AW-1:0]     rd_addr[LANES];

  always_comb begin
    rd_col = CW'(in_ch.out_column);
    for (int n = 0; n < LANES; n++) begin
      px_y[n]  = CW'(int'(in_ch.out_page) * 8 + n);
      px_in[n] = (int'(px_y[n]) < ICON_SIZE) && (int'(in_ch.out_column) < ICON_SIZE);
      case (in_ch.rotation)
        miqr_pkg::ROT_0: begin
          px_sx[n] = rd_col;
          px_sy[n] = px_y[n];
        end
        miqr_pkg::ROT_90: begin
          px_sx[n] = px_y[n];
          px_sy[n] = LAST - rd_col;
        end
        miqr_pkg::ROT_180: begin
          px_sx[n] = LAST - rd_col;
          px_sy[n] = LAST - px_y[n];
        end
        miqr_pkg::ROT_270: begin
          px_sx[n] = LAST - px_y[n];
          px_sy[n] = rd_col;
        end
        default: begin
          px_sx[n] = '0;
          px_sy[n] = '0;
        end
      endcase
      px_bank[n] = px_sx[n][LANE_W-1:0] + px_sy[n][LANE_W-1:0];
      px_addr[n] = AW'(int'(px_sy[n][CW-1:3]) * ICON_SIZE + int'(px_sx[n]));
    end
    // in-icon bits of one run land in distinct banks
    for (int b = 0; b < LANES; b++) begin
      rd_addr[b] = '0;
      for (int n = 0; n < LANES; n++) begin
        if (px_in[n] && (px_bank[n] == LANE_W'(b))) begin
          rd_addr[b] = px_addr[n];
        end
      end
    end
  end

  // bit banks
  logic rd_bit_r [LANES];

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic mem [DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_bits[b];
      end
      if (rd_en) begin
        rd_bit_r[b] <= mem[rd_addr[b]];
      end
    end
  end

  // read stage: bank select and mask travel with the bank data
  logic [LANE_W-1:0] s1_bank_r[LANES];
  logic [LANES-1:0]  s1_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_bank_r <= px_bank;
      s1_mask_r <= px_in;
    end
  end

  // output stage
  logic [7:0] rotated_nxt;
  logic [7:0] out_byte_r;

  always_comb begin
    for (int n = 0; n < LANES; n++) begin
      rotated_nxt[n] = s1_mask_r[n] & rd_bit_r[s1_bank_r[n]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en2) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_v_r) begin
      out_byte_r <= rotated_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.rotated_byte = out_byte_r;

endmodule

/* src/miqr_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the mono icon quarter rotator, bound to the top level.
// Depends on miqr_pkg for the operation codes.
module miqr_checker #(
  parameter int ICON_SIZE = 24
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input miqr_pkg::op_t in_operation,
  input logic [1:0]    in_out_page,
  input logic [4:0]    in_out_column,
  input logic          out_valid,
  input logic          out_ready,
  input logic [7:0]    out_rotated_byte
);

  logic in_acc;
  logic off_icon;

  assign in_acc   = in_valid && in_ready;
  assign off_icon = (int'(in_out_column) >= ICON_SIZE) || (int'(in_out_page) * 8 >= ICON_SIZE);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rotated_byte))
    else $error("result beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with the output register free, the read stage can always drain
  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  // a read outside the icon reaches the output as all zeros once out_ready lets it through
  a_off_icon_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == miqr_pkg::OP_READ && off_icon) ##1 out_ready
      |=> out_valid && out_rotated_byte == 8'h00)
    else $error("read outside the icon gave nonzero or late byte");

endmodule

bind mono_icon_quarter_rotator_top miqr_checker #(.ICON_SIZE(ICON_SIZE)) u_miqr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_operation     (in_ch.operation),
  .in_out_page      (in_ch.out_page),
  .in_out_column    (in_ch.out_column),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_rotated_byte (out_ch.rotated_byte)
);
